@@ rtl/okt_pkg.sv @@
// okt_pkg: shared types and constants for the ordered key table.
// Field widths, operation and status codes, controller states, cell control word.
// No dependencies.
package okt_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 64;
    localparam int CNT_W     = 7;
    localparam int ST_W      = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_UPD = 2'd2,
        OP_GET = 2'd3
    } func_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_APPLY = 2'd2
    } state_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;   // cells at or above shift_from take their upper neighbor
        logic load;    // the cell at load_idx takes the load word
    } cell_ctl_t;

endpackage

@@ rtl/okt_cell.sv @@
// okt_cell: one entry of the table chain, a key and a value register.
// Takes its upper neighbor on a shift or a new word on a load.
// Depends on okt_pkg.
module okt_cell
    import okt_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic [IDX_W-1:0]        shift_from,
    input  logic [IDX_W-1:0]        load_idx,
    input  logic signed [KEY_W-1:0] load_key,
    input  logic [VAL_W-1:0]        load_value,
    input  logic signed [KEY_W-1:0] nxt_key,
    input  logic [VAL_W-1:0]        nxt_value,
    output logic signed [KEY_W-1:0] key_q,
    output logic [VAL_W-1:0]        value_q
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic [VAL_W-1:0]        value_reg;
    logic [VAL_W-1:0]        value_next;

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctl.shift && (MY_IDX >= shift_from))
        begin
            key_next   = nxt_key;
            value_next = nxt_value;
        end
        else if (ctl.load && (MY_IDX == load_idx))
        begin
            key_next   = load_key;
            value_next = load_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

@@ rtl/ordered_key_table.sv @@
// ordered_key_table: insertion-ordered key/value table built as a chain of cells.
// Instantiates okt_cell DEPTH times; types and codes from okt_pkg.
//
// channel  direction  handshake            word
// in       input      in_valid / in_stall   func, key, new_key, value
// out      output     out_valid / out_stall status, read_value, entry_count
// cfg      input      cfg_wr_en             cfg_wr_data (capacity)
//
// Each request is accepted, then the whole chain is rotated past the compare
// point at cell 0, then the change is applied and the result register loaded.
// The rotation passes every cell; in_stall holds off new requests until idle.
// Reset clears the entry count, capacity (to 64) and control; cells hold no reset.
// A stalled result holds the apply step, so the table is changed only once.
module ordered_key_table
    import okt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CNT_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [FUNC_W-1:0]       func,
    input  logic signed [KEY_W-1:0] key,
    input  logic signed [KEY_W-1:0] new_key,
    input  logic [VAL_W-1:0]        value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [ST_W-1:0]         status,
    output logic [VAL_W-1:0]        read_value,
    output logic [CNT_W-1:0]        entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int MW = ((IW + 1) > CNT_W) ? (IW + 1) : CNT_W;
    localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    state_t                  state_reg, state_next;
    logic [IW-1:0]           cnt_reg, cnt_next;
    logic                    found_reg, found_next;
    logic                    clash_reg, clash_next;
    logic [IW-1:0]           pos_reg, pos_next;
    logic [VAL_W-1:0]        rd_reg, rd_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        cap_reg;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [VAL_W-1:0]        out_value_reg, out_value_next;
    logic [CNT_W-1:0]        out_count_reg, out_count_next;

    func_t                   req_func_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic signed [KEY_W-1:0] req_nkey_reg;
    logic [VAL_W-1:0]        req_val_reg;

    cell_ctl_t               ctl;
    logic [IW-1:0]           shift_from;
    logic [IW-1:0]           load_idx;
    logic signed [KEY_W-1:0] load_key;

    logic signed [KEY_W-1:0] cell_key [DEPTH];
    logic [VAL_W-1:0]        cell_val [DEPTH];

    logic                    in_acc;
    logic                    out_free;
    logic                    apply_go;
    logic                    head_live;
    logic                    key_hit;
    logic                    nkey_hit;
    logic                    full;
    logic [MW-1:0]           fill_m;
    logic [MW-1:0]           cap_m;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign apply_go = (state_reg == S_APPLY) && out_free;

    assign fill_m    = MW'(fill_reg);
    assign cap_m     = (MW'(cap_reg) > DEPTH_M) ? DEPTH_M : MW'(cap_reg);
    assign full      = fill_m >= cap_m;
    assign head_live = MW'(cnt_reg) < fill_m;
    assign key_hit   = head_live && (cell_key[0] == req_key_reg);
    assign nkey_hit  = head_live && (cell_key[0] == req_nkey_reg);

    // Chain of cells; the top cell wraps around to cell 0 so a full rotation
    // brings every entry home.
    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        okt_cell #(
            .IDX_W (IW),
            .INDEX (j)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .shift_from (shift_from),
            .load_idx   (load_idx),
            .load_key   (load_key),
            .load_value (req_val_reg),
            .nxt_key    (cell_key[(j + 1) % DEPTH]),
            .nxt_value  (cell_val[(j + 1) % DEPTH]),
            .key_q      (cell_key[j]),
            .value_q    (cell_val[j])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        clash_next      = clash_reg;
        pos_next        = pos_reg;
        rd_next         = rd_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        ctl             = '0;
        shift_from      = '0;
        load_idx        = '0;
        load_key        = req_key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    clash_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                ctl.shift = 1'b1;
                if (key_hit)
                begin
                    found_next = 1'b1;
                    pos_next   = cnt_reg;
                    rd_next    = cell_val[0];
                end
                // keys are unique, so a new_key match that is not the key
                // itself sits in another entry
                if (nkey_hit && !key_hit)
                begin
                    clash_next = 1'b1;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = ST_OK;
                    unique case (req_func_reg)
                        OP_ADD:
                        begin
                            if (full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else if (found_reg)
                            begin
                                out_status_next = ST_DUP;
                            end
                            else
                            begin
                                ctl.load  = 1'b1;
                                load_idx  = IW'(fill_m);
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL:
                        begin
                            if (!found_reg)
                            begin
                                out_status_next = ST_MISSING;
                            end
                            else
                            begin
                                ctl.shift  = 1'b1;
                                shift_from = pos_reg;
                                fill_next  = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_UPD:
                        begin
                            if (!found_reg)
                            begin
                                out_status_next = ST_MISSING;
                            end
                            else if (clash_reg)
                            begin
                                out_status_next = ST_DUP;
                            end
                            else
                            begin
                                ctl.load = 1'b1;
                                load_idx = pos_reg;
                                load_key = req_nkey_reg;
                            end
                        end
                        OP_GET:
                        begin
                            if (!found_reg)
                            begin
                                out_status_next = ST_MISSING;
                            end
                            else
                            begin
                                out_value_next = rd_reg;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_MISSING;
                        end
                    endcase
                    out_count_next = fill_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            clash_reg     <= 1'b0;
            fill_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            clash_reg     <= clash_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        rd_reg         <= rd_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        if (in_acc)
        begin
            req_func_reg <= func_t'(func);
            req_key_reg  <= key;
            req_nkey_reg <= new_key;
            req_val_reg  <= value;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign read_value  = out_value_reg;
    assign entry_count = out_count_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("block took no time after accepting a word");

    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_APPLY))
        else $error("result appeared outside the apply step");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_m <= DEPTH_M)
        else $error("entry count exceeds the number of cells");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_go && (req_func_reg == OP_ADD) && !full && !found_reg)
        |=> (fill_reg == CNT_W'($past(fill_reg) + CNT_W'(1))))
        else $error("successful add did not advance the entry count");

endmodule

@@ test/tb_ordered_key_table.sv @@
`timescale 1ns / 1ps
// tb_ordered_key_table: self-checking bench for ordered_key_table (uses okt_pkg).
// Directed plan, then random phases under several capacities, checked against a
// shadow table kept here.
module tb_ordered_key_table;
    import okt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2500;
    localparam int LONG_HOLD      = 400;
    localparam logic [KEY_W-1:0] KEY_MIN  = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_NEG1 = 32'hFFFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  read_value;
        logic [CNT_W-1:0]  entry_count;
    } table_reply_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CNT_W-1:0]  cap;
        func_t             op;
        logic [KEY_W-1:0]  k;
        logic [KEY_W-1:0]  nk;
        logic [VAL_W-1:0]  v;
        logic              typed;
        table_reply_t      want;
    } plan_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]        cfg_wr_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [FUNC_W-1:0]       func = OP_GET;
    logic signed [KEY_W-1:0] key = '0;
    logic signed [KEY_W-1:0] new_key = '0;
    logic [VAL_W-1:0]        value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ST_W-1:0]         status;
    logic [VAL_W-1:0]        read_value;
    logic [CNT_W-1:0]        entry_count;

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key [DEPTH_DEF];
    logic [VAL_W-1:0] shadow_val [DEPTH_DEF];
    int               shadow_count = 0;
    int               shadow_cap = int'(CAP_RESET);

    table_reply_t replies_due [$];
    plan_row_t    plan [$];

    int  mismatches = 0;
    int  replies_seen = 0;
    int  words_sent = 0;
    int  settings_run = 1;
    int  peak_count = 0;
    int  status_count [4];
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;
    bit  hold_request = 1'b0;

    ordered_key_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key         (key),
        .new_key     (new_key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic table_reply_t apply_request(func_t op, logic [KEY_W-1:0] k,
                                                   logic [KEY_W-1:0] nk,
                                                   logic [VAL_W-1:0] v);
        table_reply_t r;
        int limit;
        int pos;
        int i;
        bit clash;
        r.status = ST_OK;
        r.read_value = '0;
        limit = (shadow_cap > DEPTH_DEF) ? DEPTH_DEF : shadow_cap;
        pos = shadow_count;
        for (i = shadow_count - 1; i >= 0; i--)
        begin
            if (shadow_key[i] == k)
                pos = i;
        end
        case (op)
            OP_ADD:
            begin
                // full wins over duplicate
                if (shadow_count >= limit)
                    r.status = ST_FULL;
                else if (pos < shadow_count)
                    r.status = ST_DUP;
                else
                begin
                    shadow_key[shadow_count] = k;
                    shadow_val[shadow_count] = v;
                    shadow_count++;
                end
            end
            OP_DEL:
            begin
                if (pos >= shadow_count)
                    r.status = ST_MISSING;
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_val[i] = shadow_val[i + 1];
                    end
                    shadow_count--;
                end
            end
            OP_UPD:
            begin
                if (pos >= shadow_count)
                    r.status = ST_MISSING;
                else
                begin
                    clash = 1'b0;
                    for (i = 0; i < shadow_count; i++)
                    begin
                        if (i != pos && shadow_key[i] == nk)
                            clash = 1'b1;
                    end
                    if (clash)
                        r.status = ST_DUP;
                    else
                    begin
                        shadow_key[pos] = nk;
                        shadow_val[pos] = v;
                    end
                end
            end
            default:
            begin
                if (pos >= shadow_count)
                    r.status = ST_MISSING;
                else
                    r.read_value = shadow_val[pos];
            end
        endcase
        r.entry_count = CNT_W'(shadow_count);
        status_count[r.status]++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int stored_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < stored_pct && shadow_count > 0)
            return shadow_key[$urandom_range(0, shadow_count - 1)];
        if (r >= 90)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return KEY_NEG1;
                default: return '0;
            endcase
        end
        // narrow range so fresh keys collide now and then
        if (r >= 80)
            return KEY_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VAL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        mismatches++;
        $display("reply %0d: %s mismatch, got %0h want %0h", replies_seen, what, got, want);
    endtask

    // Called at a clock edge; returns at the edge that takes the word.
    task automatic send_request(func_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                                logic [VAL_W-1:0] v, logic typed, table_reply_t want);
        table_reply_t predicted;
        in_valid <= 1'b1;
        func <= op;
        key <= k;
        new_key <= nk;
        value <= v;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = apply_request(op, k, nk, v);
        replies_due.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic sender_gap(int pct);
        if (pct > 0 && $urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain_table();
        in_valid <= 1'b0;
        wait (replies_due.size() == 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] c);
        drain_table();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_cap = int'(c);
    endtask

    task automatic send_random(int add_pct, int del_pct);
        func_t op;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] nk;
        table_reply_t none;
        int r;
        none = '0;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            op = OP_ADD;
        else if (r < add_pct + del_pct)
            op = OP_DEL;
        else
            op = $urandom_range(0, 1) ? OP_UPD : OP_GET;
        k = pick_key(op == OP_ADD ? 25 : 70);
        nk = ($urandom_range(0, 9) == 0) ? k : pick_key(30);
        send_request(op, k, nk, pick_value(), 1'b0, none);
    endtask

    task automatic run_phase(logic [CNT_W-1:0] cap, int words, int add_pct, int del_pct,
                             int idle_pct);
        int n;
        write_capacity(cap);
        settings_run++;
        for (n = 0; n < words; n++)
        begin
            send_random(add_pct, del_pct);
            sender_gap(idle_pct);
        end
    endtask

    function automatic void step(func_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                                 logic [VAL_W-1:0] v);
        plan_row_t row;
        row = '0;
        row.op = op;
        row.k = k;
        row.nk = nk;
        row.v = v;
        plan.push_back(row);
    endfunction

    function automatic void step_known(func_t op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                                       logic [VAL_W-1:0] v, status_t s,
                                       logic [VAL_W-1:0] rd, int cnt);
        plan_row_t row;
        row = '0;
        row.op = op;
        row.k = k;
        row.nk = nk;
        row.v = v;
        row.typed = 1'b1;
        row.want.status = s;
        row.want.read_value = rd;
        row.want.entry_count = CNT_W'(cnt);
        plan.push_back(row);
    endfunction

    function automatic void cap_row(logic [CNT_W-1:0] c);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cap = c;
        plan.push_back(row);
    endfunction

    // result side: check accepted words, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            replies_seen++;
            if (replies_due.size() == 0)
                flag_mismatch("unexpected reply, status", VAL_W'(status), '0);
            else
            begin
                table_reply_t want;
                want = replies_due.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", VAL_W'(status), VAL_W'(want.status));
                if (read_value !== want.read_value)
                    flag_mismatch("read_value", read_value, want.read_value);
                if (entry_count !== want.entry_count)
                    flag_mismatch("entry_count", VAL_W'(entry_count),
                                  VAL_W'(want.entry_count));
            end
        end
        if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        foreach (status_count[i])
            status_count[i] = 0;

        step_known(OP_GET, 32'd5, '0, '0, ST_MISSING, '0, 0);
        step_known(OP_DEL, 32'd5, '0, '0, ST_MISSING, '0, 0);
        step_known(OP_UPD, 32'd5, 32'd6, '0, ST_MISSING, '0, 0);
        step_known(OP_ADD, KEY_MIN, '0, '0, ST_OK, '0, 1);
        step_known(OP_ADD, KEY_MAX, '0, VAL_ONES, ST_OK, '0, 2);
        step_known(OP_ADD, KEY_MIN, '0, 64'd9, ST_DUP, '0, 2);
        step_known(OP_GET, KEY_MAX, '0, '0, ST_OK, VAL_ONES, 2);
        step_known(OP_ADD, KEY_NEG1, '0, 64'h5555_5555_5555_5555, ST_OK, '0, 3);
        // shrink capacity under the current fill
        cap_row(CNT_W'(2));
        step_known(OP_ADD, KEY_MAX, '0, '0, ST_FULL, '0, 3);
        step_known(OP_ADD, 32'd1, '0, '0, ST_FULL, '0, 3);
        step_known(OP_UPD, KEY_MAX, KEY_NEG1, '0, ST_DUP, '0, 3);
        step_known(OP_UPD, KEY_NEG1, KEY_NEG1, 64'hAAAA_AAAA_AAAA_AAAA, ST_OK, '0, 3);
        step_known(OP_GET, KEY_NEG1, '0, '0, ST_OK, 64'hAAAA_AAAA_AAAA_AAAA, 3);
        step_known(OP_UPD, 32'd7, KEY_MIN, '0, ST_MISSING, '0, 3);
        step_known(OP_DEL, KEY_MIN, '0, '0, ST_OK, '0, 2);
        step_known(OP_GET, KEY_MAX, '0, '0, ST_OK, VAL_ONES, 2);
        step(OP_UPD, KEY_MAX, '0, 64'h0123_4567_89AB_CDEF);
        step(OP_GET, '0, '0, '0);
        step(OP_ADD, 32'h1234_5678, '0, 64'd3);
        cap_row('0);
        step(OP_DEL, '0, '0, '0);
        step_known(OP_ADD, '0, '0, 64'd4, ST_FULL, '0, 1);
        cap_row(CNT_W'(127));
        step(OP_ADD, '0, '0, 64'hFEDC_BA98_7654_3210);
        step(OP_DEL, KEY_NEG1, '0, '0);
        step(OP_DEL, '0, '0, '0);
        step(OP_GET, KEY_MIN, '0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                write_capacity(plan[i].cap);
                settings_run++;
            end
            else
            begin
                send_request(plan[i].op, plan[i].k, plan[i].nk, plan[i].v,
                             plan[i].typed, plan[i].want);
                sender_gap(20);
            end
        end

        // fill to the top and past it
        run_phase(CNT_W'(64), 110, 80, 5, 20);
        write_capacity(CNT_W'(20));
        // hold results back while the sender keeps offering
        hold_request = 1'b1;
        run_phase(CNT_W'(20), 50, 20, 60, 25);
        run_phase('0, 25, 50, 10, 0);
        run_phase(CNT_W'(127), 60, 30, 60, 30);
        run_phase(CNT_W'(1), 50, 30, 60, 20);
        run_phase(CNT_W'(5), 50, 50, 25, 15);
        quiet = 1'b1;
        run_phase(CNT_W'(64), 60, 40, 20, 0);

        drain_table();
        repeat (DEPTH_DEF + 8) @(posedge clk);

        $display("Ran %0d requests under %0d capacity settings, table peaked at %0d entries",
                 words_sent, settings_run, peak_count);
        $display("Replies: %0d ok, %0d full, %0d duplicate, %0d not found",
                 status_count[ST_OK], status_count[ST_FULL], status_count[ST_DUP],
                 status_count[ST_MISSING]);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
